// File: rtl/core/tcpmq_pkg.sv
// ----------------------------------------------------------------------------
// Three-class priority message queue package
// Shared payload types, field widths, operation, class and status codes.
// ----------------------------------------------------------------------------
package tcpmq_pkg;

  localparam int HANDLE_W = 32;
  localparam int LEVEL_W  = 2;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;

  localparam int DEFAULT_QUEUE_DEPTH = 16;
  localparam int DEFAULT_HANDLE_BITS = 32;

  localparam logic [COUNT_W-1:0] CAPACITY_RESET = 5'd16;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_TAKE = 1'b1;

  localparam logic [LEVEL_W-1:0] LVL_GENERAL   = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_IMPORTANT = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_IMMEDIATE = 2'd2;
  localparam logic [LEVEL_W-1:0] LVL_INVALID   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BUSY  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_LEVEL = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NULL  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd5;

  typedef struct packed {
    logic                func;
    logic [LEVEL_W-1:0]  msg_level;
    logic [HANDLE_W-1:0] msg_handle;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] taken_handle;
    logic [LEVEL_W-1:0]  taken_level;
    logic [COUNT_W-1:0]  occupancy;
  } rsp_t;

endpackage

// File: rtl/core/three_class_priority_message_queue.sv
// ----------------------------------------------------------------------------
// Three-class priority message queue
// Holds message handles in an immediate slot and two FIFOs that share one
// synchronous memory, and answers push and take requests by strict priority.
// ----------------------------------------------------------------------------
// Each request on the input channel is a push or a take, and each produces
// exactly one response on the output channel, in request order.
// A response is presented in the cycle after its request transfer. The block
// takes one request per cycle as long as the output side keeps up: a new
// request is taken in the same cycle as the waiting response is taken.
// A take from a FIFO reads the shared handle memory in the request cycle;
// the registered read data becomes the response handle in the next cycle.
// While a response is stalled, the read data and all response fields hold,
// and no further request is taken.
// The capacity register is written through its own channel, which is always
// ready; it should be written only while no request is outstanding.
// Reset empties all three classes, clears the counters and sets the
// capacity to sixteen. The memory contents are not cleared; a FIFO entry
// is only read after it has been written.
// ----------------------------------------------------------------------------
module three_class_priority_message_queue #(
  parameter int QUEUE_DEPTH = tcpmq_pkg::DEFAULT_QUEUE_DEPTH,
  parameter int HANDLE_BITS = tcpmq_pkg::DEFAULT_HANDLE_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  tcpmq_pkg::req_t                    in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output tcpmq_pkg::rsp_t                    out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [tcpmq_pkg::COUNT_W-1:0]      cfg_data_i
);

  localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int ADDR_W  = PTR_W + 1;
  localparam int STORE_W = (HANDLE_BITS < tcpmq_pkg::HANDLE_W) ? HANDLE_BITS
                                                               : tcpmq_pkg::HANDLE_W;
  localparam int CapLimit = (QUEUE_DEPTH < 31) ? QUEUE_DEPTH : 31;
  localparam logic [tcpmq_pkg::COUNT_W-1:0] CAP_MAX  = tcpmq_pkg::COUNT_W'(CapLimit);
  localparam logic [PTR_W-1:0]              PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  localparam int CW = tcpmq_pkg::COUNT_W;

  logic [STORE_W-1:0] mem [0:(1 << ADDR_W)-1];
  logic [STORE_W-1:0] rdata_q;

  logic [CW-1:0]      capacity_q;
  logic               urgent_valid_q, urgent_valid_d;
  logic [STORE_W-1:0] urgent_handle_q, urgent_handle_d;
  logic [PTR_W-1:0]   high_rd_q, high_rd_d, high_wr_q, high_wr_d;
  logic [PTR_W-1:0]   low_rd_q, low_rd_d, low_wr_q, low_wr_d;
  logic [CW-1:0]      high_cnt_q, high_cnt_d, low_cnt_q, low_cnt_d;
  logic [CW-1:0]      total_q, total_d;

  logic                              out_valid_q;
  logic [tcpmq_pkg::STATUS_W-1:0]    status_q, status_d;
  logic [tcpmq_pkg::LEVEL_W-1:0]     level_q, level_d;
  logic [STORE_W-1:0]                handle_q, handle_d;
  logic                              sel_mem_q, sel_mem_d;

  logic               mem_we, mem_re;
  logic [ADDR_W-1:0]  waddr, raddr;
  logic [STORE_W-1:0] req_handle;
  logic [CW-1:0]      cap_eff;
  logic               in_fire;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign req_handle  = in_data_i.msg_handle[STORE_W-1:0];
  assign cap_eff     = (capacity_q > CAP_MAX) ? CAP_MAX : capacity_q;

  always_comb begin
    urgent_valid_d  = urgent_valid_q;
    urgent_handle_d = urgent_handle_q;
    high_rd_d       = high_rd_q;
    high_wr_d       = high_wr_q;
    low_rd_d        = low_rd_q;
    low_wr_d        = low_wr_q;
    high_cnt_d      = high_cnt_q;
    low_cnt_d       = low_cnt_q;
    total_d         = total_q;
    status_d        = tcpmq_pkg::ST_OK;
    level_d         = tcpmq_pkg::LVL_GENERAL;
    handle_d        = '0;
    sel_mem_d       = 1'b0;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    waddr           = {1'b0, high_wr_q};
    raddr           = {1'b0, high_rd_q};
    if (in_data_i.func == tcpmq_pkg::FUNC_PUSH) begin
      priority if (req_handle == '0) begin
        status_d = tcpmq_pkg::ST_NULL;
      end else if (total_q >= cap_eff) begin
        status_d = tcpmq_pkg::ST_FULL;
      end else if (in_data_i.msg_level == tcpmq_pkg::LVL_INVALID) begin
        status_d = tcpmq_pkg::ST_LEVEL;
      end else if (in_data_i.msg_level == tcpmq_pkg::LVL_IMMEDIATE) begin
        if (urgent_valid_q) begin
          status_d = tcpmq_pkg::ST_BUSY;
        end else begin
          urgent_valid_d  = 1'b1;
          urgent_handle_d = req_handle;
          total_d         = total_q + CW'(1);
        end
      end else if (in_data_i.msg_level == tcpmq_pkg::LVL_IMPORTANT) begin
        mem_we     = in_fire;
        waddr      = {1'b0, high_wr_q};
        high_wr_d  = ptr_next(high_wr_q);
        high_cnt_d = high_cnt_q + CW'(1);
        total_d    = total_q + CW'(1);
      end else begin
        mem_we    = in_fire;
        waddr     = {1'b1, low_wr_q};
        low_wr_d  = ptr_next(low_wr_q);
        low_cnt_d = low_cnt_q + CW'(1);
        total_d   = total_q + CW'(1);
      end
    end else begin
      priority if (total_q == '0) begin
        status_d = tcpmq_pkg::ST_EMPTY;
      end else if (urgent_valid_q) begin
        urgent_valid_d = 1'b0;
        handle_d       = urgent_handle_q;
        level_d        = tcpmq_pkg::LVL_IMMEDIATE;
        total_d        = total_q - CW'(1);
      end else if (high_cnt_q != '0) begin
        mem_re     = in_fire;
        raddr      = {1'b0, high_rd_q};
        sel_mem_d  = 1'b1;
        level_d    = tcpmq_pkg::LVL_IMPORTANT;
        high_rd_d  = ptr_next(high_rd_q);
        high_cnt_d = high_cnt_q - CW'(1);
        total_d    = total_q - CW'(1);
      end else if (low_cnt_q != '0) begin
        mem_re    = in_fire;
        raddr     = {1'b1, low_rd_q};
        sel_mem_d = 1'b1;
        level_d   = tcpmq_pkg::LVL_GENERAL;
        low_rd_d  = ptr_next(low_rd_q);
        low_cnt_d = low_cnt_q - CW'(1);
        total_d   = total_q - CW'(1);
      end else begin
        status_d = tcpmq_pkg::ST_EMPTY;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= req_handle;
    end
    if (mem_re) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q     <= tcpmq_pkg::CAPACITY_RESET;
      urgent_valid_q <= 1'b0;
      high_rd_q      <= '0;
      high_wr_q      <= '0;
      low_rd_q       <= '0;
      low_wr_q       <= '0;
      high_cnt_q     <= '0;
      low_cnt_q      <= '0;
      total_q        <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        capacity_q <= cfg_data_i;
      end
      if (in_fire) begin
        urgent_valid_q <= urgent_valid_d;
        high_rd_q      <= high_rd_d;
        high_wr_q      <= high_wr_d;
        low_rd_q       <= low_rd_d;
        low_wr_q       <= low_wr_d;
        high_cnt_q     <= high_cnt_d;
        low_cnt_q      <= low_cnt_d;
        total_q        <= total_d;
        out_valid_q    <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      urgent_handle_q <= urgent_handle_d;
      status_q        <= status_d;
      level_q         <= level_d;
      handle_q        <= handle_d;
      sel_mem_q       <= sel_mem_d;
    end
  end

  assign out_valid_o             = out_valid_q;
  assign out_data_o.status       = status_q;
  assign out_data_o.taken_handle = tcpmq_pkg::HANDLE_W'(sel_mem_q ? rdata_q : handle_q);
  assign out_data_o.taken_level  = level_q;
  assign out_data_o.occupancy    = total_q;

endmodule

// File: rtl/core/tcpmq_checker.sv
// ----------------------------------------------------------------------------
// Three-class priority message queue checker
// Port-level properties of the queue, attached to the top level by bind.
// ----------------------------------------------------------------------------
module tcpmq_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input tcpmq_pkg::rsp_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("Stalled response changed.");

  a_handle_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != tcpmq_pkg::ST_OK
    |-> out_data_o.taken_handle == '0)
    else $error("Handle returned with a failing status.");

  a_level_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.taken_level != tcpmq_pkg::LVL_GENERAL
    |-> out_data_o.status == tcpmq_pkg::ST_OK)
    else $error("Class reported with a failing status.");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == tcpmq_pkg::ST_EMPTY
    |-> out_data_o.occupancy == '0)
    else $error("Empty status with nonzero occupancy.");

endmodule

bind three_class_priority_message_queue tcpmq_checker u_tcpmq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// Testbench for the three-class priority message queue
// A directed table covers the reset state, field extremes, every status code
// and capacity edge cases. It is followed by random phases that change the
// capacity while messages are held and stall both channels at random.
// Every response is compared field by field with a predicted response.
// ----------------------------------------------------------------------------
module tb_top;
  import tcpmq_pkg::*;

  typedef struct {
    bit               is_cap_write;
    logic [COUNT_W-1:0] cap;
    req_t             op;
    bit               typed;
    rsp_t             reply;
  } plan_row_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  req_t in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  rsp_t out_data_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [COUNT_W-1:0] cfg_data_i;

  logic [COUNT_W-1:0]  cap_model;
  bit                  slot_full;
  logic [HANDLE_W-1:0] slot_handle;
  logic [HANDLE_W-1:0] important_q[$];
  logic [HANDLE_W-1:0] general_q[$];

  rsp_t      expected_replies[$];
  plan_row_t plan[$];
  int        fail_cnt;
  bit        calm;

  three_class_priority_message_queue i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (calm) return 0;
    if (k < 60) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic int msgs_held();
    return int'(slot_full) + important_q.size() + general_q.size();
  endfunction

  function automatic rsp_t next_reply(req_t r);
    rsp_t o;
    int   limit;
    o = '0;
    limit = (cap_model > DEFAULT_QUEUE_DEPTH) ? DEFAULT_QUEUE_DEPTH : int'(cap_model);
    if (r.func == FUNC_PUSH) begin
      if (r.msg_handle == '0) begin
        o.status = ST_NULL;
      end else if (msgs_held() >= limit) begin
        o.status = ST_FULL;
      end else if (r.msg_level == LVL_INVALID) begin
        o.status = ST_LEVEL;
      end else if (r.msg_level == LVL_IMMEDIATE) begin
        if (slot_full) begin
          o.status = ST_BUSY;
        end else begin
          slot_full = 1'b1;
          slot_handle = r.msg_handle;
        end
      end else if (r.msg_level == LVL_IMPORTANT) begin
        important_q.push_back(r.msg_handle);
      end else begin
        general_q.push_back(r.msg_handle);
      end
    end else begin
      if (slot_full) begin
        o.taken_handle = slot_handle;
        o.taken_level = LVL_IMMEDIATE;
        slot_full = 1'b0;
      end else if (important_q.size() != 0) begin
        o.taken_handle = important_q.pop_front();
        o.taken_level = LVL_IMPORTANT;
      end else if (general_q.size() != 0) begin
        o.taken_handle = general_q.pop_front();
        o.taken_level = LVL_GENERAL;
      end else begin
        o.status = ST_EMPTY;
      end
    end
    o.occupancy = COUNT_W'(msgs_held());
    return o;
  endfunction

  function automatic void add_op(logic f, logic [LEVEL_W-1:0] l, logic [HANDLE_W-1:0] h);
    plan_row_t s;
    s.is_cap_write = 1'b0;
    s.cap = '0;
    s.op = '{func: f, msg_level: l, msg_handle: h};
    s.typed = 1'b0;
    s.reply = '0;
    plan.push_back(s);
  endfunction

  function automatic void add_op_checked(logic f, logic [LEVEL_W-1:0] l,
                                         logic [HANDLE_W-1:0] h, logic [STATUS_W-1:0] st,
                                         logic [HANDLE_W-1:0] th, logic [LEVEL_W-1:0] tl,
                                         logic [COUNT_W-1:0] occ);
    add_op(f, l, h);
    plan[$].typed = 1'b1;
    plan[$].reply = '{status: st, taken_handle: th, taken_level: tl, occupancy: occ};
  endfunction

  function automatic void add_cap_write(logic [COUNT_W-1:0] c);
    add_op(FUNC_PUSH, LVL_GENERAL, '0);
    plan[$].is_cap_write = 1'b1;
    plan[$].cap = c;
  endfunction

  task automatic send_op(req_t r, bit typed, rsp_t want);
    int   gap;
    rsp_t model;
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= r;
    do @(posedge clk_i); while (!in_ready_o);
    model = next_reply(r);
    expected_replies.push_back(typed ? want : model);
  endtask

  task automatic write_capacity(logic [COUNT_W-1:0] c);
    in_valid_i <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= c;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cap_model = c;
  endtask

  function automatic req_t rand_op(int push_pct);
    req_t r;
    int   k;
    r.func = ($urandom_range(0, 99) < push_pct) ? FUNC_PUSH : FUNC_TAKE;
    if (r.func == FUNC_TAKE) begin
      r.msg_level = LEVEL_W'($urandom_range(0, 3));
      r.msg_handle = $urandom;
      return r;
    end
    k = $urandom_range(0, 99);
    r.msg_level = (k < 8) ? LVL_INVALID : LEVEL_W'($urandom_range(0, 2));
    k = $urandom_range(0, 99);
    if (k < 5) r.msg_handle = '0;
    else if (k < 10) r.msg_handle = '1;
    else if (k < 15) r.msg_handle = HANDLE_W'(1) << $urandom_range(0, HANDLE_W - 1);
    else r.msg_handle = $urandom;
    return r;
  endfunction

  initial begin
    rsp_t want;
    rsp_t got;
    int   stall;
    stall = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got = out_data_o;
        if (expected_replies.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10) $display("unexpected response: %p", got);
        end else begin
          want = expected_replies.pop_front();
          if (got.status !== want.status || got.taken_handle !== want.taken_handle ||
              got.taken_level !== want.taken_level || got.occupancy !== want.occupancy) begin
            fail_cnt++;
            if (fail_cnt <= 10) begin
              $display("mismatch: expected status %0d handle %h level %0d occupancy %0d",
                       want.status, want.taken_handle, want.taken_level, want.occupancy);
              $display("          actual   status %0d handle %h level %0d occupancy %0d",
                       got.status, got.taken_handle, got.taken_level, got.occupancy);
            end
          end
        end
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else begin
        out_ready_i <= 1'b1;
        stall = gap_len();
      end
    end
  end

  initial begin
    int                 sent;
    int                 n;
    int                 push_pct;
    int                 k;
    logic [COUNT_W-1:0] c;
    fail_cnt = 0;
    calm = 1'b0;
    cap_model = CAPACITY_RESET;
    slot_full = 1'b0;
    slot_handle = '0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;

    add_op_checked(FUNC_TAKE, LVL_GENERAL, '0, ST_EMPTY, '0, LVL_GENERAL, 5'd0);
    add_op_checked(FUNC_PUSH, LVL_GENERAL, '0, ST_NULL, '0, LVL_GENERAL, 5'd0);
    add_op_checked(FUNC_PUSH, LVL_INVALID, '1, ST_LEVEL, '0, LVL_GENERAL, 5'd0);
    add_op_checked(FUNC_PUSH, LVL_IMMEDIATE, '1, ST_OK, '0, LVL_GENERAL, 5'd1);
    add_op_checked(FUNC_PUSH, LVL_IMMEDIATE, 32'h1, ST_BUSY, '0, LVL_GENERAL, 5'd1);
    add_op(FUNC_PUSH, LVL_IMPORTANT, 32'h8000_0000);
    add_op(FUNC_PUSH, LVL_GENERAL, 32'h0000_0001);
    add_op(FUNC_PUSH, LVL_IMPORTANT, 32'h7FFF_FFFF);
    add_op(FUNC_TAKE, LVL_INVALID, '1);
    add_op(FUNC_TAKE, LVL_IMMEDIATE, 32'h5555_5555);
    add_op(FUNC_TAKE, LVL_IMPORTANT, 32'hAAAA_AAAA);
    add_op(FUNC_TAKE, LVL_GENERAL, '0);
    add_op_checked(FUNC_TAKE, LVL_GENERAL, '0, ST_EMPTY, '0, LVL_GENERAL, 5'd0);
    add_op_checked(FUNC_PUSH, LVL_INVALID, '0, ST_NULL, '0, LVL_GENERAL, 5'd0);
    add_cap_write(5'd0);
    add_op_checked(FUNC_PUSH, LVL_GENERAL, 32'hAAAA_AAAA, ST_FULL, '0, LVL_GENERAL, 5'd0);
    add_op_checked(FUNC_PUSH, LVL_INVALID, 32'h5555_5555, ST_FULL, '0, LVL_GENERAL, 5'd0);
    add_cap_write(5'd1);
    add_op(FUNC_PUSH, LVL_GENERAL, 32'h1234_5678);
    add_op_checked(FUNC_PUSH, LVL_IMMEDIATE, 32'h9, ST_FULL, '0, LVL_GENERAL, 5'd1);
    add_cap_write(5'd31);
    add_op(FUNC_PUSH, LVL_IMMEDIATE, 32'h0000_FFFF);
    add_op_checked(FUNC_PUSH, LVL_IMMEDIATE, 32'hFFFF_0000, ST_BUSY, '0, LVL_GENERAL, 5'd2);
    add_op(FUNC_TAKE, LVL_GENERAL, '0);
    add_op(FUNC_TAKE, LVL_GENERAL, '0);
    add_op_checked(FUNC_TAKE, LVL_GENERAL, '0, ST_EMPTY, '0, LVL_GENERAL, 5'd0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_cap_write) write_capacity(plan[i].cap);
      else send_op(plan[i].op, plan[i].typed, plan[i].reply);
    end

    // Phases are not drained in between, so a lower capacity often meets
    // a fuller queue than it allows.
    sent = 0;
    for (int ph = 0; sent < 450; ph++) begin
      k = $urandom_range(0, 99);
      if (ph == 0) c = 5'd31;
      else if (ph == 1) c = 5'd0;
      else if (ph == 2) c = 5'd16;
      else if (k < 25) c = 5'd16;
      else if (k < 40) c = 5'd31;
      else if (k < 50) c = 5'd0;
      else c = COUNT_W'($urandom_range(1, 16));
      write_capacity(c);
      calm = ($urandom_range(0, 3) == 0);
      push_pct = (ph == 0) ? 85 : $urandom_range(25, 80);
      n = $urandom_range(25, 60);
      repeat (n) begin
        send_op(rand_op(push_pct), 1'b0, '0);
        sent++;
      end
    end

    in_valid_i <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/tcpmq_pkg.sv
rtl/core/three_class_priority_message_queue.sv
rtl/core/tcpmq_checker.sv
dv/tb_top.sv
